// File: hdl/serial_packet_deframer_unit_macros.svh
// Assertion helpers for the serial packet deframer.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef SERIAL_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define SERIAL_PACKET_DEFRAMER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/spd_pkg.sv
`default_nettype none

package spd_pkg;

    // Packet geometry.
    localparam int PACKET_BYTES = 64;
    localparam int POS_W        = $clog2(PACKET_BYTES);
    localparam int LEN_W        = 6;
    localparam int BYTE_W       = 8;

    localparam logic [POS_W-1:0] POS_LEN   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_TYPE  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DATA  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_FINAL = POS_W'(PACKET_BYTES - 1);

    // Length field codes.
    localparam logic [BYTE_W-1:0] LEN_MASK  = 8'h3F;
    localparam logic [LEN_W-1:0]  CONT_LEN  = 6'd63;
    localparam logic [LEN_W-1:0]  EMPTY_LEN = 6'd0;
    localparam logic [POS_W-1:0]  FULL_DATA = POS_W'(62);

    // Input command codes.
    typedef enum logic {
        CMD_BYTE  = 1'b0,
        CMD_FLUSH = 1'b1
    } spd_cmd_t;

    // One result transaction.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_data;
        logic [BYTE_W-1:0] msg_type;
        logic              last;
        logic              to_fileserver;
    } spd_result_t;

    // Handshake between the parser and the output register.
    typedef struct packed {
        logic valid;
        logic ready;
    } spd_hs_t;

endpackage

`default_nettype wire

// File: hdl/spd_stream_if.sv
`default_nettype none

// Received byte channel.
interface spd_in_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [spd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// Deframed data channel.
interface spd_out_if;
    logic                       valid;
    logic                       ready;
    logic [spd_pkg::BYTE_W-1:0] data_byte;
    logic                       has_data;
    logic [spd_pkg::BYTE_W-1:0] msg_type;
    logic                       last;
    logic                       to_fileserver;

    modport source (output valid, output data_byte, output has_data, output msg_type,
                    output last, output to_fileserver, input ready);
    modport sink   (input valid, input data_byte, input has_data, input msg_type,
                    input last, input to_fileserver, output ready);
endinterface

`default_nettype wire

// File: hdl/serial_packet_deframer_unit.sv
// Channel    Role    Payload
// rx_chan    sink    cmd (1 bit), rx_byte (8 bits)
// res_chan   source  data_byte, has_data, msg_type, last, to_fileserver
// cfg        write   cfg_we, cfg_wdata (comm_code, 8 bits)
//
// One transaction is accepted per cycle unless a stall on res_chan holds the input register.
// The path is an input register, the packet decode and a result register.
// Header and padding bytes, and flushes, pass through without a result.
// rst_n clears the parser state, both valid flags and comm_code at once.
// A stall on res_chan backs up through the result and input registers to rx_chan.
`default_nettype none

module serial_packet_deframer_unit
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    spd_in_if.sink                          rx_chan,
    spd_out_if.source                       res_chan,
    input  wire logic                       cfg_we,
    input  wire logic [spd_pkg::BYTE_W-1:0] cfg_wdata
);

    logic [spd_pkg::BYTE_W-1:0] comm_code_reg;
    logic                       res_ready;
    spd_pkg::spd_hs_t           res_hs;
    spd_pkg::spd_result_t       res;

    // File server type code register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comm_code_reg <= '0;
        end
        else if (cfg_we)
        begin
            comm_code_reg <= cfg_wdata;
        end
    end

    // Input register and packet decode.
    spd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_chan   (rx_chan),
        .comm_code (comm_code_reg),
        .res_ready (res_ready),
        .res_hs    (res_hs),
        .res       (res)
    );

    // Result register.
    spd_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_hs    (res_hs),
        .res       (res),
        .res_ready (res_ready),
        .res_chan  (res_chan)
    );

endmodule

`default_nettype wire

// File: hdl/spd_parser.sv
`default_nettype none
`include "serial_packet_deframer_unit_macros.svh"

module spd_parser
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    spd_in_if.sink                          rx_chan,
    input  wire logic [spd_pkg::BYTE_W-1:0] comm_code,
    input  wire logic                       res_ready,
    output spd_pkg::spd_hs_t                res_hs,
    output spd_pkg::spd_result_t            res
);

    logic                       in_valid_reg;
    logic                       in_cmd_reg;
    logic [spd_pkg::BYTE_W-1:0] in_byte_reg;

    logic [spd_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [spd_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [spd_pkg::BYTE_W-1:0] type_reg, type_next;

    logic                       in_take;
    logic                       stage_go;
    logic                       emit;
    logic [spd_pkg::POS_W-1:0]  data_idx;

    // The input register drains whenever the output register can take a result.
    assign stage_go       = in_valid_reg && res_ready;
    assign rx_chan.ready  = !in_valid_reg || res_ready;
    assign in_take        = rx_chan.valid && rx_chan.ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx_chan.ready)
        begin
            in_valid_reg <= rx_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg  <= rx_chan.cmd;
            in_byte_reg <= rx_chan.rx_byte;
        end
    end

    // Packet decode: header capture, data window and end of message.
    assign data_idx = pos_reg - spd_pkg::POS_DATA;

    always_comb
    begin
        pos_next            = pos_reg + spd_pkg::POS_W'(1);
        len_next            = len_reg;
        type_next           = type_reg;
        emit                = 1'b0;
        res.data_byte       = '0;
        res.has_data        = 1'b0;
        res.msg_type        = type_reg;
        res.last            = 1'b0;
        res.to_fileserver   = (type_reg == comm_code);

        if (in_cmd_reg == spd_pkg::CMD_FLUSH)
        begin
            pos_next  = '0;
            len_next  = '0;
            type_next = '0;
        end
        else if (pos_reg == spd_pkg::POS_LEN)
        begin
            len_next = spd_pkg::LEN_W'(in_byte_reg & spd_pkg::LEN_MASK);
        end
        else if (pos_reg == spd_pkg::POS_TYPE)
        begin
            type_next = in_byte_reg;
        end
        else if (len_reg == spd_pkg::CONT_LEN)
        begin
            // Continuation packet: every data byte belongs to the message.
            if (data_idx < spd_pkg::FULL_DATA)
            begin
                emit          = 1'b1;
                res.data_byte = in_byte_reg;
                res.has_data  = 1'b1;
            end
        end
        else if (len_reg == spd_pkg::EMPTY_LEN)
        begin
            // Empty final packet: one end marker at the last byte.
            if (pos_reg == spd_pkg::POS_FINAL)
            begin
                emit     = 1'b1;
                res.last = 1'b1;
            end
        end
        else if (data_idx < spd_pkg::POS_W'(len_reg))
        begin
            emit          = 1'b1;
            res.data_byte = in_byte_reg;
            res.has_data  = 1'b1;
            res.last      = (data_idx == spd_pkg::POS_W'(len_reg - spd_pkg::LEN_W'(1)));
        end

        if ((in_cmd_reg != spd_pkg::CMD_FLUSH) && (pos_reg == spd_pkg::POS_FINAL))
        begin
            pos_next = '0;
        end
    end

    assign res_hs.valid = in_valid_reg && emit;
    assign res_hs.ready = res_ready;

    // Parser state advances once per drained transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            len_reg  <= '0;
            type_reg <= '0;
        end
        else if (stage_go)
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            type_reg <= type_next;
        end
    end

    // Checks on the parser state and the result it forms.
    `SPD_ASSERT_NEXT(a_flush_clears,
        stage_go && (in_cmd_reg == spd_pkg::CMD_FLUSH),
        (pos_reg == '0) && (len_reg == '0) && (type_reg == '0),
        "flush did not clear the parser")
    `SPD_ASSERT_NEXT(a_pos_wraps,
        stage_go && (in_cmd_reg == spd_pkg::CMD_BYTE) && (pos_reg == spd_pkg::POS_FINAL),
        pos_reg == '0,
        "byte position did not wrap at packet end")
    `SPD_ASSERT_SAME(a_marker_form,
        res_hs.valid && !res.has_data,
        res.last && (res.data_byte == '0),
        "end marker without last or with data")
    `SPD_ASSERT_SAME(a_no_header_result,
        in_valid_reg && ((pos_reg == spd_pkg::POS_LEN) || (pos_reg == spd_pkg::POS_TYPE)),
        !res_hs.valid,
        "header byte produced a result")

endmodule

`default_nettype wire

// File: hdl/spd_out_stage.sv
`default_nettype none
`include "serial_packet_deframer_unit_macros.svh"

module spd_out_stage
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire spd_pkg::spd_hs_t     res_hs,
    input  wire spd_pkg::spd_result_t res,
    output logic                      res_ready,
    spd_out_if.source                 res_chan
);

    logic                 valid_reg;
    spd_pkg::spd_result_t data_reg;
    logic                 load;

    // Space is free when the register is empty or is being emptied this cycle.
    assign res_ready = !valid_reg || res_chan.ready;
    assign load      = res_hs.valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_hs.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    // Drive the output channel straight from the result register.
    assign res_chan.valid         = valid_reg;
    assign res_chan.data_byte     = data_reg.data_byte;
    assign res_chan.has_data      = data_reg.has_data;
    assign res_chan.msg_type      = data_reg.msg_type;
    assign res_chan.last          = data_reg.last;
    assign res_chan.to_fileserver = data_reg.to_fileserver;

    // A loaded result must show on the next cycle, and nothing loads into a held one.
    `SPD_ASSERT_NEXT(a_load_shows, load, valid_reg, "loaded result not presented")
    `SPD_ASSERT_SAME(a_no_overwrite, valid_reg && !res_chan.ready, !load, "held result overwritten")
    `SPD_ASSERT_SAME(a_ready_agrees, 1'b1, res_ready == res_hs.ready, "ready seen by parser differs")

endmodule

`default_nettype wire
